### rtl/vlmd_pkg.sv
// ----------------------------------------------------------------------------
// vlmd_pkg
// Shared types and constants of the 3D local maximum detector.
// ----------------------------------------------------------------------------
package vlmd_pkg;

    localparam int VALUE_W   = 32;
    localparam int COORD_W   = 8;
    localparam int COUNT_W   = 24;
    localparam int SIZE_W    = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    localparam logic [SIZE_W-1:0]  SIZE_RESET = 9'd256;
    localparam logic [SIZE_W-1:0]  SIZE_MIN   = 9'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 24'hFF_FFFF;

    // result queue behind the compare pipeline
    localparam int OUT_FIFO_DEPTH = 8;
    localparam int OUT_FIFO_AW    = $clog2(OUT_FIFO_DEPTH);

    typedef logic signed [VALUE_W-1:0] t_word;

    // one column of the window along z: current plane, z-1, z-2
    typedef struct packed {
        t_word z0;
        t_word z1;
        t_word z2;
    } t_col;

    // plane buffer entry: scores at z-2 and z-1 for one (x, y)
    typedef struct packed {
        t_word p2;
        t_word p1;
    } t_plane_pair;

    // row buffer entry: columns at y-2 and y-1 for one x
    typedef struct packed {
        t_col r2;
        t_col r1;
    } t_row_pair;

    // per-beat control carried along the compare pipeline
    typedef struct packed {
        logic               test;
        logic               last;
        logic               first;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_side;

    typedef struct packed {
        logic a_v;
        logic b_v;
        logic c_v;
    } t_pipe_stat;

    typedef struct packed {
        logic [COORD_W-1:0] peak_x;
        logic [COORD_W-1:0] peak_y;
        logic [COORD_W-1:0] peak_z;
        t_word              peak_value;
        logic               is_peak;
        logic               end_of_volume;
        logic [COUNT_W-1:0] peak_count;
    } t_result;

endpackage

### rtl/vlmd_if.sv
// ----------------------------------------------------------------------------
// vlmd_if
// Valid/ready channels of the detector: voxel in, peak out, register write.
// ----------------------------------------------------------------------------
interface vlmd_voxel_if;
    import vlmd_pkg::*;

    logic  valid;
    logic  ready;
    t_word voxel_value;

    modport source (output valid, output voxel_value, input ready);
    modport sink (input valid, input voxel_value, output ready);
endinterface

interface vlmd_peak_if;
    import vlmd_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] peak_x;
    logic [COORD_W-1:0] peak_y;
    logic [COORD_W-1:0] peak_z;
    t_word              peak_value;
    logic               is_peak;
    logic               end_of_volume;
    logic [COUNT_W-1:0] peak_count;

    modport source (
        output valid, output peak_x, output peak_y, output peak_z,
        output peak_value, output is_peak, output end_of_volume,
        output peak_count, input ready
    );
    modport sink (
        input valid, input peak_x, input peak_y, input peak_z,
        input peak_value, input is_peak, input end_of_volume,
        input peak_count, output ready
    );
endinterface

interface vlmd_cfg_if;
    import vlmd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SIZE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/vlmd_peak.sv
// ----------------------------------------------------------------------------
// vlmd_peak
// Window compare pipeline: 3x3 column maxima, x shift, center test, count.
// ----------------------------------------------------------------------------
module vlmd_peak (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  vlmd_pkg::t_col       i_col0,
    input  vlmd_pkg::t_col       i_col1,
    input  vlmd_pkg::t_col       i_col2,
    input  vlmd_pkg::t_side      i_side,
    output vlmd_pkg::t_pipe_stat o_stat,
    output logic                 o_res_valid,
    output vlmd_pkg::t_result    o_res
);
    import vlmd_pkg::*;

    function automatic t_word max2(input t_word a, input t_word b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_word max3(input t_word a, input t_word b, input t_word c);
        return max2(max2(a, b), c);
    endfunction

    logic         r_a_v, r_b_v, r_c_v;
    t_word        r_a_m0, r_a_m1, r_a_m2, r_a_cen;
    t_side        r_a_side;
    t_word        r_b_cm, r_b_cen;
    t_side        r_b_side;
    t_word        r_h_cm1, r_h_cm2, r_h_cen;
    t_word        r_c_wmax, r_c_cen;
    t_side        r_c_side;
    logic [COUNT_W-1:0] r_count;

    logic               peak;
    logic [COUNT_W-1:0] base;
    logic [COUNT_W-1:0] n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_a_m0   <= max3(i_col0.z0, i_col0.z1, i_col0.z2);
            r_a_m1   <= max3(i_col1.z0, i_col1.z1, i_col1.z2);
            r_a_m2   <= max3(i_col2.z0, i_col2.z1, i_col2.z2);
            r_a_cen  <= i_col1.z1;
            r_a_side <= i_side;
        end
        if (r_a_v) begin
            r_b_cm   <= max3(r_a_m0, r_a_m1, r_a_m2);
            r_b_cen  <= r_a_cen;
            r_b_side <= r_a_side;
        end
        // column history along x; the center sits one column back
        if (r_b_v) begin
            r_h_cm1  <= r_b_cm;
            r_h_cm2  <= r_h_cm1;
            r_h_cen  <= r_b_cen;
            r_c_wmax <= max3(r_b_cm, r_h_cm1, r_h_cm2);
            r_c_cen  <= r_h_cen;
            r_c_side <= r_b_side;
        end
    end

    // window max includes the center itself, so >= means no neighbor is greater
    assign peak    = r_c_side.test && (r_c_cen >= r_c_wmax);
    assign base    = r_c_side.first ? '0 : r_count;
    assign n_count = (peak && (base != COUNT_MAX)) ? base + 1'b1 : base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (r_c_v) begin
            r_count <= n_count;
        end
    end

    assign o_stat.a_v = r_a_v;
    assign o_stat.b_v = r_b_v;
    assign o_stat.c_v = r_c_v;

    assign o_res_valid         = r_c_v && (peak || r_c_side.last);
    assign o_res.peak_x        = peak ? r_c_side.x : '0;
    assign o_res.peak_y        = peak ? r_c_side.y : '0;
    assign o_res.peak_z        = peak ? r_c_side.z : '0;
    assign o_res.peak_value    = peak ? r_c_cen : '0;
    assign o_res.is_peak       = peak;
    assign o_res.end_of_volume = r_c_side.last;
    assign o_res.peak_count    = n_count;

endmodule

### rtl/volume_local_maximum_detect.sv
// ----------------------------------------------------------------------------
// volume_local_maximum_detect
// 26-neighbor local maximum detection over a raster-ordered 3D volume.
// ----------------------------------------------------------------------------
// Path: a result reaches o_peak through the memory read, column max, window max
//   and test stages and then the result queue.
// Throughput: one voxel per cycle while the result queue has room for it; the
//   plane and row buffers each take one read and one write per cycle.
// Reset: sizes return to 256, position, count and pipeline clear. The buffers
//   are not cleared; only entries written in the current volume feed a tested window.
module volume_local_maximum_detect #(
    parameter int MAX_X = 256,
    parameter int MAX_Y = 256,
    parameter int MAX_Z = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    vlmd_voxel_if.sink         i_voxel,
    vlmd_cfg_if.sink           i_cfg,
    vlmd_peak_if.source        o_peak
);
    import vlmd_pkg::*;

    localparam int CAP_X    = (MAX_X < 256) ? MAX_X : 256;
    localparam int CAP_Y    = (MAX_Y < 256) ? MAX_Y : 256;
    localparam int CAP_Z    = (MAX_Z < 256) ? MAX_Z : 256;
    localparam int XW       = $clog2(CAP_X);
    localparam int YW       = $clog2(CAP_Y);
    localparam int PA_W     = XW + YW;
    localparam int PM_DEPTH = 1 << PA_W;
    localparam int RM_DEPTH = 1 << XW;

    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [SIZE_W-1:0] v,
        input logic [SIZE_W-1:0] cap
    );
        logic [SIZE_W-1:0] r;
        r = v;
        if (v < SIZE_MIN) r = SIZE_MIN;
        else if (v > cap) r = cap;
        return r;
    endfunction

    // configuration
    logic [SIZE_W-1:0] r_size_x, r_size_y, r_size_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RESET;
            r_size_y <= SIZE_RESET;
            r_size_z <= SIZE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_SIZE_X: r_size_x <= i_cfg.data;
                REG_SIZE_Y: r_size_y <= i_cfg.data;
                REG_SIZE_Z: r_size_z <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // raster position and latched sizes
    logic [COORD_W-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic [COORD_W-1:0] n_pos_x, n_pos_y, n_pos_z;
    logic [SIZE_W-1:0]  r_lat_x, r_lat_y, r_lat_z;
    logic [SIZE_W-1:0]  eff_x, eff_y, eff_z;
    logic               first, end_x, end_y, end_z;
    logic               in_fire;
    t_side              side0;

    assign in_fire = i_voxel.valid && i_voxel.ready;
    assign first   = (r_pos_x == '0) && (r_pos_y == '0) && (r_pos_z == '0);

    // sizes are taken when the first voxel of a volume arrives
    assign eff_x = first ? clamp_size(r_size_x, SIZE_W'(CAP_X)) : r_lat_x;
    assign eff_y = first ? clamp_size(r_size_y, SIZE_W'(CAP_Y)) : r_lat_y;
    assign eff_z = first ? clamp_size(r_size_z, SIZE_W'(CAP_Z)) : r_lat_z;

    assign end_x = ({1'b0, r_pos_x} + 9'd1) >= eff_x;
    assign end_y = ({1'b0, r_pos_y} + 9'd1) >= eff_y;
    assign end_z = ({1'b0, r_pos_z} + 9'd1) >= eff_z;

    assign n_pos_x = end_x ? '0 : r_pos_x + 1'b1;
    assign n_pos_y = !end_x ? r_pos_y : (end_y ? '0 : r_pos_y + 1'b1);
    assign n_pos_z = !(end_x && end_y) ? r_pos_z : (end_z ? '0 : r_pos_z + 1'b1);

    assign side0.test  = (r_pos_x >= 8'd2) && (r_pos_y >= 8'd2) && (r_pos_z >= 8'd2);
    assign side0.last  = end_x && end_y && end_z;
    assign side0.first = first;
    assign side0.x     = r_pos_x - 1'b1;
    assign side0.y     = r_pos_y - 1'b1;
    assign side0.z     = r_pos_z - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
            r_lat_x <= clamp_size(SIZE_RESET, SIZE_W'(CAP_X));
            r_lat_y <= clamp_size(SIZE_RESET, SIZE_W'(CAP_Y));
            r_lat_z <= clamp_size(SIZE_RESET, SIZE_W'(CAP_Z));
        end else if (in_fire) begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_pos_z <= n_pos_z;
            r_lat_x <= eff_x;
            r_lat_y <= eff_y;
            r_lat_z <= eff_z;
        end
    end

    // plane and row buffers, read on accept, written back in the cycle after.
    // Consecutive voxels never share an address, so no forwarding is needed.
    t_plane_pair r_pm [PM_DEPTH];
    t_row_pair   r_rm [RM_DEPTH];
    t_plane_pair r_pm_q;
    t_row_pair   r_rm_q;

    logic              r_s1_v;
    t_word             r_s1_val;
    logic [PA_W-1:0]   r_s1_pa;
    logic [XW-1:0]     r_s1_ra;
    t_side             r_s1_side;
    t_col              col_new;
    t_plane_pair       pm_wd;
    t_row_pair         rm_wd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_pm_q    <= r_pm[{r_pos_y[YW-1:0], r_pos_x[XW-1:0]}];
            r_rm_q    <= r_rm[r_pos_x[XW-1:0]];
            r_s1_val  <= i_voxel.voxel_value;
            r_s1_pa   <= {r_pos_y[YW-1:0], r_pos_x[XW-1:0]};
            r_s1_ra   <= r_pos_x[XW-1:0];
            r_s1_side <= side0;
        end
    end

    assign col_new.z0 = r_s1_val;
    assign col_new.z1 = r_pm_q.p1;
    assign col_new.z2 = r_pm_q.p2;
    assign pm_wd.p1   = r_s1_val;
    assign pm_wd.p2   = r_pm_q.p1;
    assign rm_wd.r1   = col_new;
    assign rm_wd.r2   = r_rm_q.r1;

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_pm[r_s1_pa] <= pm_wd;
            r_rm[r_s1_ra] <= rm_wd;
        end
    end

    // compare pipeline
    t_pipe_stat stat;
    logic       res_valid;
    t_result    res;

    vlmd_peak u_peak (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_v),
        .i_col0      (col_new),
        .i_col1      (r_rm_q.r1),
        .i_col2      (r_rm_q.r2),
        .i_side      (r_s1_side),
        .o_stat      (stat),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result queue; input is held back so every beat in flight has a slot
    t_result                r_fifo [OUT_FIFO_DEPTH];
    logic [OUT_FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [OUT_FIFO_AW:0]   r_fifo_cnt;
    logic [2:0]             inflight;
    logic [4:0]             credit_used;
    logic                   pop;

    assign inflight    = {2'b0, r_s1_v} + 3'($countones(stat));
    assign credit_used = 5'(r_fifo_cnt) + 5'(inflight);
    assign i_voxel.ready = credit_used < 5'(OUT_FIFO_DEPTH);
    assign pop         = o_peak.valid && o_peak.ready;

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_fifo[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (res_valid) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)       r_rd_ptr <= r_rd_ptr + 1'b1;
            if (res_valid && !pop) begin
                r_fifo_cnt <= r_fifo_cnt + 1'b1;
            end else if (pop && !res_valid) begin
                r_fifo_cnt <= r_fifo_cnt - 1'b1;
            end
        end
    end

    assign o_peak.valid         = r_fifo_cnt != '0;
    assign o_peak.peak_x        = r_fifo[r_rd_ptr].peak_x;
    assign o_peak.peak_y        = r_fifo[r_rd_ptr].peak_y;
    assign o_peak.peak_z        = r_fifo[r_rd_ptr].peak_z;
    assign o_peak.peak_value    = r_fifo[r_rd_ptr].peak_value;
    assign o_peak.is_peak       = r_fifo[r_rd_ptr].is_peak;
    assign o_peak.end_of_volume = r_fifo[r_rd_ptr].end_of_volume;
    assign o_peak.peak_count    = r_fifo[r_rd_ptr].peak_count;

endmodule

### rtl/vlmd_checker.sv
// ----------------------------------------------------------------------------
// vlmd_checker
// Port-level checks on the peak output channel of the detector.
// ----------------------------------------------------------------------------
module vlmd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           i_ready,
    input logic [vlmd_pkg::COORD_W-1:0]   i_peak_x,
    input logic [vlmd_pkg::COORD_W-1:0]   i_peak_y,
    input logic [vlmd_pkg::COORD_W-1:0]   i_peak_z,
    input logic [vlmd_pkg::VALUE_W-1:0]   i_peak_value,
    input logic                           i_is_peak,
    input logic                           i_end_of_volume,
    input logic [vlmd_pkg::COUNT_W-1:0]   i_peak_count
);
    import vlmd_pkg::*;

    logic               fire;
    logic [COUNT_W-1:0] r_prev_cnt;
    logic [COUNT_W-1:0] exp_cnt;

    assign fire    = i_valid && i_ready;
    assign exp_cnt = !i_is_peak ? r_prev_cnt :
                     (r_prev_cnt == COUNT_MAX) ? COUNT_MAX : r_prev_cnt + 1'b1;

    // count seen on the last beat of the open volume
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_cnt <= '0;
        end else if (fire) begin
            r_prev_cnt <= i_end_of_volume ? '0 : i_peak_count;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable({i_peak_x, i_peak_y, i_peak_z,
            i_peak_value, i_is_peak, i_end_of_volume, i_peak_count}))
        else $error("output beat changed while stalled");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> i_peak_count == exp_cnt)
        else $error("peak count does not step by one per peak");

    a_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && i_is_peak |-> i_peak_x != '0 && i_peak_y != '0 && i_peak_z != '0
            && i_peak_x != '1 && i_peak_y != '1 && i_peak_z != '1)
        else $error("peak reported on a border voxel");

    a_nopeak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !i_is_peak |-> i_end_of_volume && i_peak_x == '0 && i_peak_y == '0
            && i_peak_z == '0 && i_peak_value == '0)
        else $error("non-peak beat that is not a clean end of volume");

endmodule

bind volume_local_maximum_detect vlmd_checker u_vlmd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_peak.valid),
    .i_ready         (o_peak.ready),
    .i_peak_x        (o_peak.peak_x),
    .i_peak_y        (o_peak.peak_y),
    .i_peak_z        (o_peak.peak_z),
    .i_peak_value    (o_peak.peak_value),
    .i_is_peak       (o_peak.is_peak),
    .i_end_of_volume (o_peak.end_of_volume),
    .i_peak_count    (o_peak.peak_count)
);

### verif/volume_local_maximum_detect_test.sv
// ----------------------------------------------------------------------------
// volume_local_maximum_detect_test
// Streams raster-ordered volumes of several sizes into the detector and
// checks every result against a behavioral predictor of the 26-neighbor test.
// ----------------------------------------------------------------------------
module volume_local_maximum_detect_test;
    import vlmd_pkg::*;

    localparam int SIZE_CAP       = 256;
    localparam int LINE_DEPTH     = 2 * SIZE_CAP * SIZE_CAP + 2 * SIZE_CAP + 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int RANDOM_VOXELS  = 450;
    localparam int CALM_TAIL      = 200;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam t_word SCORE_MIN = 32'sh8000_0000;
    localparam t_word SCORE_MAX = 32'sh7FFF_FFFF;

    typedef enum int {SCORE_FULL, SCORE_NARROW, SCORE_EXTREME, SCORE_FLAT} t_score_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    vlmd_voxel_if voxel_ch ();
    vlmd_cfg_if   cfg_ch ();
    vlmd_peak_if  peak_ch ();

    volume_local_maximum_detect u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_voxel (voxel_ch),
        .i_cfg   (cfg_ch),
        .o_peak  (peak_ch)
    );

    // predictor state
    logic [SIZE_W-1:0]  req_x, req_y, req_z;
    int                 vol_x, vol_y, vol_z;
    t_word              score_line [LINE_DEPTH];
    int                 line_wr;
    int                 pos_x, pos_y, pos_z;
    logic [COUNT_W-1:0] found_peaks;
    t_result            peak_expect_q [$];

    t_result peak_want;
    int      error_count;
    bit      idle_on;
    int      idle_cycles;
    int      stall_left;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int clamp_size(logic [SIZE_W-1:0] v);
        if (v < SIZE_MIN) return int'(SIZE_MIN);
        if (v > SIZE_CAP) return SIZE_CAP;
        return int'(v);
    endfunction

    function automatic int vol_count();
        return clamp_size(req_x) * clamp_size(req_y) * clamp_size(req_z);
    endfunction

    function automatic t_word look_back(int delay);
        return score_line[(line_wr + LINE_DEPTH - delay) % LINE_DEPTH];
    endfunction

    function automatic void predict_voxel(t_word v);
        t_result r;
        t_word   centre;
        bit      peak;
        bit      last;
        int      plane;
        int      dx, dy, dz;
        peak   = 1'b0;
        centre = '0;
        // sizes latch on the first voxel of a volume
        if (pos_x == 0 && pos_y == 0 && pos_z == 0) begin
            vol_x       = clamp_size(req_x);
            vol_y       = clamp_size(req_y);
            vol_z       = clamp_size(req_z);
            found_peaks = '0;
        end
        score_line[line_wr] = v;
        if (pos_x >= 2 && pos_y >= 2 && pos_z >= 2) begin
            plane  = vol_x * vol_y;
            centre = look_back(plane + vol_x + 1);
            peak   = 1'b1;
            for (dz = 0; dz < 3; dz++)
                for (dy = 0; dy < 3; dy++)
                    for (dx = 0; dx < 3; dx++)
                        if (look_back(dz * plane + dy * vol_x + dx) > centre) peak = 1'b0;
            if (peak && found_peaks != COUNT_MAX) found_peaks++;
        end
        last = (pos_x + 1 >= vol_x) && (pos_y + 1 >= vol_y) && (pos_z + 1 >= vol_z);
        r = '0;
        if (peak) begin
            r.peak_x     = COORD_W'(pos_x - 1);
            r.peak_y     = COORD_W'(pos_y - 1);
            r.peak_z     = COORD_W'(pos_z - 1);
            r.peak_value = centre;
            r.is_peak    = 1'b1;
        end
        r.end_of_volume = last;
        r.peak_count    = found_peaks;
        if (peak || last) peak_expect_q.push_back(r);
        line_wr = (line_wr + 1) % LINE_DEPTH;
        pos_x++;
        if (pos_x >= vol_x) begin
            pos_x = 0;
            pos_y++;
            if (pos_y >= vol_y) begin
                pos_y = 0;
                pos_z++;
                if (pos_z >= vol_z) pos_z = 0;
            end
        end
    endfunction

    function automatic t_word pick_score(t_score_mode mode, t_word flat);
        case (mode)
            SCORE_FULL:   return t_word'($urandom);
            SCORE_NARROW: return t_word'($urandom_range(0, 3)) - 32'sd2;
            SCORE_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       return SCORE_MIN;
                    1:       return SCORE_MAX;
                    2:       return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default:      return flat;
        endcase
    endfunction

    // valid stays high between back-to-back beats; it drops only in a gap
    task automatic send_voxel(t_word v);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            voxel_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        voxel_ch.valid       <= 1'b1;
        voxel_ch.voxel_value <= v;
        @(posedge i_clk);
        while (!voxel_ch.ready) @(posedge i_clk);
        predict_voxel(v);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            REG_SIZE_X: req_x = val;
            REG_SIZE_Y: req_y = val;
            REG_SIZE_Z: req_z = val;
            default: ;
        endcase
    endtask

    task automatic set_sizes(logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy,
                             logic [SIZE_W-1:0] sz);
        write_reg(REG_SIZE_X, sx);
        write_reg(REG_SIZE_Y, sy);
        write_reg(REG_SIZE_Z, sz);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain_results();
        voxel_ch.valid <= 1'b0;
        while (peak_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic stream_volume(t_score_mode mode, t_word flat);
        int n;
        n = vol_count();
        repeat (n) send_voxel(pick_score(mode, flat));
    endtask

    // 3x3x3 volume: corner voxel, centre voxel, everything else
    task automatic send_cube(t_word centre, t_word rest, t_word corner);
        int i;
        for (i = 0; i < 27; i++)
            send_voxel(i == 13 ? centre : (i == 0 ? corner : rest));
    endtask

    task automatic test_cube_cases();
        set_sizes(9'd3, 9'd3, 9'd3);
        // flat cube: the tie makes a peak on the same beat as the end flag
        send_cube(32'sd5, 32'sd5, 32'sd5);
        send_cube(SCORE_MAX, SCORE_MIN, SCORE_MIN);
        // end of volume with no peak found
        send_cube(SCORE_MIN, SCORE_MAX, SCORE_MAX);
        // zero beats minus one only under signed order
        send_cube(-32'sd1, -32'sd1, 32'sd0);
        drain_results();
    endtask

    task automatic test_size_clamp();
        write_reg(REG_SPARE, 9'h1FF);
        set_sizes(9'd0, 9'd1, 9'd2);
        stream_volume(SCORE_NARROW, '0);
        drain_results();
    endtask

    task automatic test_plateau();
        set_sizes(9'd5, 9'd4, 9'd3);
        stream_volume(SCORE_FLAT, SCORE_MIN);
        drain_results();
    endtask

    // long thin volumes: long rows or many planes with small sizes clamped up
    task automatic test_size_extremes();
        set_sizes(9'd24, 9'd0, 9'd3);
        stream_volume(SCORE_NARROW, '0);
        drain_results();
        set_sizes(9'd2, 9'd1, 9'd30);
        stream_volume(SCORE_EXTREME, '0);
        drain_results();
    endtask

    task automatic test_random_volumes();
        int          sent;
        int          axis;
        bit          first;
        logic [SIZE_W-1:0] sz [3];
        sent  = 0;
        first = 1'b1;
        while (sent < RANDOM_VOXELS) begin
            if (sent >= RANDOM_VOXELS - CALM_TAIL) idle_on = 1'b0;
            // keeping the sizes streams the next volume straight after the wrap
            if (first || $urandom_range(0, 2) != 0) begin
                drain_results();
                for (axis = 0; axis < 3; axis++) begin
                    sz[axis] = SIZE_W'($urandom_range(3, 7));
                    if ($urandom_range(0, 7) == 0) sz[axis] = SIZE_W'($urandom_range(0, 2));
                end
                if ($urandom_range(0, 7) == 0) begin
                    sz = '{9'd3, 9'd3, 9'd3};
                    sz[$urandom_range(0, 2)] = SIZE_W'($urandom_range(8, 24));
                end
                set_sizes(sz[0], sz[1], sz[2]);
                first = 1'b0;
            end
            sent += vol_count();
            stream_volume(t_score_mode'($urandom_range(0, 3)), t_word'($urandom));
        end
        drain_results();
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        voxel_ch.valid       <= 1'b0;
        voxel_ch.voxel_value <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= '0;
        cfg_ch.data          <= '0;
        req_x       = SIZE_RESET;
        req_y       = SIZE_RESET;
        req_z       = SIZE_RESET;
        line_wr     = 0;
        pos_x       = 0;
        pos_y       = 0;
        pos_z       = 0;
        found_peaks = '0;
        error_count = 0;
        idle_on     = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_cube_cases();
        test_size_clamp();
        test_plateau();
        test_size_extremes();
        test_random_volumes();

        if (error_count == 0) begin
            $display("volume_local_maximum_detect_test: clean");
        end else begin
            $display("volume_local_maximum_detect_test: errors");
        end
        $finish;
    end

    // result side: ready drops in random stall bursts
    initial begin
        peak_ch.ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                peak_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 12);
                peak_ch.ready <= 1'b0;
            end else begin
                peak_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && peak_ch.valid && peak_ch.ready) begin
            if (peak_expect_q.size() == 0) begin
                $error("peak beat with no result expected");
                error_count++;
            end else begin
                peak_want = peak_expect_q.pop_front();
                if (peak_ch.peak_x !== peak_want.peak_x) begin
                    $error("peak_x: expected %0d, got %0d", peak_want.peak_x, peak_ch.peak_x);
                    error_count++;
                end
                if (peak_ch.peak_y !== peak_want.peak_y) begin
                    $error("peak_y: expected %0d, got %0d", peak_want.peak_y, peak_ch.peak_y);
                    error_count++;
                end
                if (peak_ch.peak_z !== peak_want.peak_z) begin
                    $error("peak_z: expected %0d, got %0d", peak_want.peak_z, peak_ch.peak_z);
                    error_count++;
                end
                if (peak_ch.peak_value !== peak_want.peak_value) begin
                    $error("peak_value: expected %0d, got %0d",
                           peak_want.peak_value, peak_ch.peak_value);
                    error_count++;
                end
                if (peak_ch.is_peak !== peak_want.is_peak) begin
                    $error("is_peak: expected %0d, got %0d", peak_want.is_peak, peak_ch.is_peak);
                    error_count++;
                end
                if (peak_ch.end_of_volume !== peak_want.end_of_volume) begin
                    $error("end_of_volume: expected %0d, got %0d",
                           peak_want.end_of_volume, peak_ch.end_of_volume);
                    error_count++;
                end
                if (peak_ch.peak_count !== peak_want.peak_count) begin
                    $error("peak_count: expected %0d, got %0d",
                           peak_want.peak_count, peak_ch.peak_count);
                    error_count++;
                end
            end
        end
    end

    // counts cycles without any beat on any channel
    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((voxel_ch.valid && voxel_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
                || (peak_ch.valid && peak_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("volume_local_maximum_detect_test: errors");
            $finish;
        end
    end

endmodule
